@@ rtl/core/vtyp_pkg.sv @@
package vtyp_pkg;

  localparam int COORD_W      = 16;
  localparam int SQ_W         = 2 * COORD_W;
  localparam int DEG_W        = 9;
  localparam int IDX_W        = 6;
  localparam int TAB_N        = 1 << IDX_W;
  localparam int TAB_W        = 64;
  localparam int HALF_W       = TAB_W / 2;
  localparam int PART_W       = SQ_W + HALF_W;
  localparam int PROD_W       = SQ_W + TAB_W;
  localparam int OCT_MAX      = 44;
  localparam int SEARCH_STEPS = IDX_W;
  localparam int SERIES_TERMS = 30;
  localparam int IN_DATA_W    = ((3 * COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((2 * DEG_W + 7) / 8) * 8;

  localparam logic [TAB_W-1:0] PI_Q62  = 64'hC90FDAA22168C234;
  localparam logic [TAB_W-1:0] ONE_Q62 = 64'h4000000000000000;

  localparam logic [DEG_W-1:0] DEG_HALF     = 9'd45;
  localparam logic [DEG_W-1:0] DEG_OCT_TOP  = 9'd89;
  localparam logic [DEG_W-1:0] DEG_RIGHT    = 9'd90;
  localparam logic [DEG_W-1:0] DEG_STRAIGHT = 9'd180;
  localparam logic [DEG_W-1:0] DEG_DOWN     = 9'd270;
  localparam logic [DEG_W-1:0] DEG_FULL     = 9'd360;

  typedef logic [TAB_N-1:0][TAB_W-1:0] tab_t;

  // Squared sine or cosine of each whole degree in Q62, from a power series
  // in Q62 fixed point. Only evaluated to build the constant tables below.
  function automatic tab_t gen_tab(input logic want_sin);
    tab_t              t;
    logic [TAB_W-1:0]  theta;
    logic [TAB_W-1:0]  term;
    logic [TAB_W-1:0]  s;
    logic [TAB_W-1:0]  c;
    logic [2*TAB_W-1:0] prod;
    t = '0;
    for (int unsigned k = 0; k < TAB_N; k++) begin
      theta = (PI_Q62 / 64'd180) * 64'(k) + ((PI_Q62 % 64'd180) * 64'(k)) / 64'd180;
      term  = ONE_Q62;
      s     = '0;
      c     = ONE_Q62;
      for (int unsigned n = 1; n <= SERIES_TERMS; n++) begin
        prod = (2*TAB_W)'(term) * (2*TAB_W)'(theta);
        term = prod[125:62] / 64'(n);
        case (n[1:0])
          2'd1:    s = s + term;
          2'd2:    c = c - term;
          2'd3:    s = s - term;
          default: c = c + term;
        endcase
      end
      if (want_sin) begin
        prod = (2*TAB_W)'(s) * (2*TAB_W)'(s);
      end else begin
        prod = (2*TAB_W)'(c) * (2*TAB_W)'(c);
      end
      t[k] = prod[125:62];
    end
    return t;
  endfunction

  localparam tab_t SIN2_TAB = gen_tab(1'b1);
  localparam tab_t COS2_TAB = gen_tab(1'b0);

  // How the quadrant angle is decided: exactly (zero, right, half) or by the
  // octant search, below or above 45 degrees.
  typedef enum logic [2:0] {
    Q_ZERO,
    Q_RIGHT,
    Q_HALF,
    Q_LOW,
    Q_HIGH
  } quad_t;

  typedef struct packed {
    logic [SQ_W-1:0]  num;
    logic [SQ_W-1:0]  den;
    logic [IDX_W-1:0] lo;
  } oct_t;

  typedef struct packed {
    logic  hz_zero;
    logic  x_neg;
    logic  y_neg;
    logic  z_pos;
    logic  z_neg;
    quad_t yaw_q;
    quad_t pitch_q;
  } side_t;

endpackage

@@ rtl/core/vtyp_step.sv @@
module vtyp_step import vtyp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] probe,
  input  logic             in_valid,
  output logic             in_ready,
  input  oct_t             in_yaw,
  input  oct_t             in_pitch,
  input  side_t            in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output oct_t             out_yaw,
  output oct_t             out_pitch,
  output side_t            out_side
);

  logic va_r;
  logic vb_r;
  logic rdy_a;
  logic rdy_b;

  oct_t  lane_in [2];
  oct_t  a_oct_r [2];
  oct_t  b_oct_r [2];
  side_t a_side_r;
  side_t b_side_r;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  assign lane_in[0] = in_yaw;
  assign lane_in[1] = in_pitch;

  assign out_valid = vb_r;
  assign out_yaw   = b_oct_r[0];
  assign out_pitch = b_oct_r[1];
  assign out_side  = b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= in_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_side_r <= in_side;
    end
    if (rdy_b && va_r) begin
      b_side_r <= a_side_r;
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [IDX_W-1:0]  cand_nxt;
    logic              ok_nxt;
    logic [TAB_W-1:0]  cos2;
    logic [TAB_W-1:0]  sin2;
    logic [PART_W-1:0] pc_hi_nxt;
    logic [PART_W-1:0] pc_lo_nxt;
    logic [PART_W-1:0] ps_hi_nxt;
    logic [PART_W-1:0] ps_lo_nxt;
    logic [IDX_W-1:0]  cand_r;
    logic              ok_r;
    logic [PART_W-1:0] pc_hi_r;
    logic [PART_W-1:0] pc_lo_r;
    logic [PART_W-1:0] ps_hi_r;
    logic [PART_W-1:0] ps_lo_r;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    oct_t              oct_nxt;

    // First half: candidate degree and the partial products of both sides.
    always_comb begin
      cand_nxt  = lane_in[g].lo | probe;
      ok_nxt    = (cand_nxt <= IDX_W'(OCT_MAX));
      cos2      = COS2_TAB[cand_nxt];
      sin2      = SIN2_TAB[cand_nxt];
      pc_hi_nxt = PART_W'(lane_in[g].num) * PART_W'(cos2[TAB_W-1:HALF_W]);
      pc_lo_nxt = PART_W'(lane_in[g].num) * PART_W'(cos2[HALF_W-1:0]);
      ps_hi_nxt = PART_W'(lane_in[g].den) * PART_W'(sin2[TAB_W-1:HALF_W]);
      ps_lo_nxt = PART_W'(lane_in[g].den) * PART_W'(sin2[HALF_W-1:0]);
    end

    // Second half: the angle is at least the candidate when
    // num * cos^2 >= den * sin^2; keep the candidate then.
    always_comb begin
      lhs     = {pc_hi_r, {HALF_W{1'b0}}} + PROD_W'(pc_lo_r);
      rhs     = {ps_hi_r, {HALF_W{1'b0}}} + PROD_W'(ps_lo_r);
      oct_nxt = a_oct_r[g];
      if (ok_r && (lhs >= rhs)) begin
        oct_nxt.lo = cand_r;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_a && in_valid) begin
        a_oct_r[g] <= lane_in[g];
        cand_r     <= cand_nxt;
        ok_r       <= ok_nxt;
        pc_hi_r    <= pc_hi_nxt;
        pc_lo_r    <= pc_lo_nxt;
        ps_hi_r    <= ps_hi_nxt;
        ps_lo_r    <= ps_lo_nxt;
      end
      if (rdy_b && va_r) begin
        b_oct_r[g] <= oct_nxt;
      end
    end
  end

endmodule

@@ rtl/core/vector_to_yaw_pitch_unit.sv @@
// Channel   Ports      Direction  Content
// --------  ---------  ---------  -----------------------------------------
// input     in_*       slave      one direction vector (x, y, z) per beat
// result    out_*      master     pitch and yaw in whole degrees per beat
//
// A beat passes stage 1, stage 2, the six binary steps of the degree search
// (each a multiply stage and a compare stage) and the output register; a new
// vector can be taken in every cycle unless a stall holds in_tready low. Reset
// clears only the valid bits of the stages. Every stage has its own ready, so
// a stalled output holds its beat while bubbles further up fill in.
module vector_to_yaw_pitch_unit import vtyp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata: vec_x [15:0], vec_y [31:16], vec_z [47:32]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: pitch_deg [8:0], yaw_deg [17:9], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic signed [COORD_W-1:0] vec_x;
  logic signed [COORD_W-1:0] vec_y;
  logic signed [COORD_W-1:0] vec_z;
  logic [COORD_W-1:0]        ax;
  logic [COORD_W-1:0]        ay;
  logic [COORD_W-1:0]        az;

  logic             v1_r;
  logic [SQ_W-1:0]  ax2_r;
  logic [SQ_W-1:0]  ay2_r;
  logic [SQ_W-1:0]  az2_r;
  side_t            s1_side_r;
  side_t            s1_side_nxt;

  logic             v2_r;
  logic [SQ_W-1:0]  r2;
  oct_t             s2_yaw_nxt;
  oct_t             s2_pitch_nxt;
  side_t            s2_side_nxt;
  oct_t             s2_yaw_r;
  oct_t             s2_pitch_r;
  side_t            s2_side_r;

  logic             e_s1;
  logic             e_s2;
  logic             e_out;

  logic             step_valid [SEARCH_STEPS+1];
  logic             step_ready [SEARCH_STEPS+1];
  oct_t             step_yaw   [SEARCH_STEPS+1];
  oct_t             step_pitch [SEARCH_STEPS+1];
  side_t            step_side  [SEARCH_STEPS+1];

  logic             out_valid_r;
  logic [DEG_W-1:0] pitch_r;
  logic [DEG_W-1:0] yaw_r;
  logic [DEG_W-1:0] pitch_nxt;
  logic [DEG_W-1:0] yaw_nxt;
  logic [DEG_W-1:0] yaw_m;
  logic [DEG_W-1:0] pitch_m;
  side_t            fin_side;

  function automatic quad_t classify(input logic [SQ_W-1:0] a2, input logic [SQ_W-1:0] b2);
    quad_t q;
    if (a2 == '0) begin
      q = Q_ZERO;
    end else if (b2 == '0) begin
      q = Q_RIGHT;
    end else if (a2 == b2) begin
      q = Q_HALF;
    end else if (a2 < b2) begin
      q = Q_LOW;
    end else begin
      q = Q_HIGH;
    end
    return q;
  endfunction

  function automatic oct_t order_pair(input logic [SQ_W-1:0] a2, input logic [SQ_W-1:0] b2);
    oct_t o;
    o.lo = '0;
    if (a2 < b2) begin
      o.num = a2;
      o.den = b2;
    end else begin
      o.num = b2;
      o.den = a2;
    end
    return o;
  endfunction

  function automatic logic [DEG_W-1:0] quad_deg(input quad_t q, input logic [IDX_W-1:0] lo);
    logic [DEG_W-1:0] d;
    case (q)
      Q_ZERO:  d = '0;
      Q_RIGHT: d = DEG_RIGHT;
      Q_HALF:  d = DEG_HALF;
      Q_LOW:   d = DEG_W'(lo);
      Q_HIGH:  d = DEG_OCT_TOP - DEG_W'(lo);
      default: d = '0;
    endcase
    return d;
  endfunction

  // Stall chain: a stage moves when it is empty or the next one moves.
  assign e_out     = !out_valid_r || out_tready;
  assign e_s2      = !v2_r || step_ready[0];
  assign e_s1      = !v1_r || e_s2;
  assign in_tready = e_s1;

  // Stage 1: magnitudes, squares and sign flags.
  always_comb begin
    vec_x = in_tdata[COORD_W-1:0];
    vec_y = in_tdata[2*COORD_W-1:COORD_W];
    vec_z = in_tdata[3*COORD_W-1:2*COORD_W];
    ax    = vec_x[COORD_W-1] ? -vec_x : vec_x;
    ay    = vec_y[COORD_W-1] ? -vec_y : vec_y;
    az    = vec_z[COORD_W-1] ? -vec_z : vec_z;
    s1_side_nxt         = '0;
    s1_side_nxt.hz_zero = (vec_x == '0) && (vec_y == '0);
    s1_side_nxt.x_neg   = vec_x[COORD_W-1];
    s1_side_nxt.y_neg   = vec_y[COORD_W-1];
    s1_side_nxt.z_neg   = vec_z[COORD_W-1];
    s1_side_nxt.z_pos   = !vec_z[COORD_W-1] && (vec_z != '0);
    s1_side_nxt.yaw_q   = Q_ZERO;
    s1_side_nxt.pitch_q = Q_ZERO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (e_s1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_s1 && in_tvalid) begin
      ax2_r     <= SQ_W'(ax) * SQ_W'(ax);
      ay2_r     <= SQ_W'(ay) * SQ_W'(ay);
      az2_r     <= SQ_W'(az) * SQ_W'(az);
      s1_side_r <= s1_side_nxt;
    end
  end

  // Stage 2: horizontal radius squared, exact cases and search operands.
  always_comb begin
    r2                  = ax2_r + ay2_r;
    s2_side_nxt         = s1_side_r;
    s2_side_nxt.yaw_q   = classify(ay2_r, ax2_r);
    s2_side_nxt.pitch_q = classify(az2_r, r2);
    s2_yaw_nxt          = order_pair(ay2_r, ax2_r);
    s2_pitch_nxt        = order_pair(az2_r, r2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (e_s2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e_s2 && v1_r) begin
      s2_yaw_r   <= s2_yaw_nxt;
      s2_pitch_r <= s2_pitch_nxt;
      s2_side_r  <= s2_side_nxt;
    end
  end

  assign step_valid[0]            = v2_r;
  assign step_yaw[0]              = s2_yaw_r;
  assign step_pitch[0]            = s2_pitch_r;
  assign step_side[0]             = s2_side_r;
  assign step_ready[SEARCH_STEPS] = e_out;

  // Binary search for the largest whole degree below 45, one bit per step.
  for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_step
    vtyp_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .probe     (IDX_W'(1 << (SEARCH_STEPS - 1 - i))),
      .in_valid  (step_valid[i]),
      .in_ready  (step_ready[i]),
      .in_yaw    (step_yaw[i]),
      .in_pitch  (step_pitch[i]),
      .in_side   (step_side[i]),
      .out_valid (step_valid[i+1]),
      .out_ready (step_ready[i+1]),
      .out_yaw   (step_yaw[i+1]),
      .out_pitch (step_pitch[i+1]),
      .out_side  (step_side[i+1])
    );
  end

  // Final stage: fold the quadrant angle into the full circle.
  always_comb begin
    fin_side = step_side[SEARCH_STEPS];
    yaw_m    = quad_deg(fin_side.yaw_q, step_yaw[SEARCH_STEPS].lo);
    pitch_m  = quad_deg(fin_side.pitch_q, step_pitch[SEARCH_STEPS].lo);
    if (fin_side.x_neg) begin
      // An inexact angle lies strictly inside the degree, so the mirror
      // drops one more to keep truncation.
      yaw_m = DEG_STRAIGHT - yaw_m
            - DEG_W'((fin_side.yaw_q == Q_LOW) || (fin_side.yaw_q == Q_HIGH));
    end
    if (fin_side.y_neg && (yaw_m != '0)) begin
      yaw_m = DEG_FULL - yaw_m;
    end
    if (fin_side.z_neg && (pitch_m != '0)) begin
      pitch_m = DEG_FULL - pitch_m;
    end
    if (fin_side.hz_zero) begin
      yaw_nxt   = '0;
      pitch_nxt = fin_side.z_pos ? DEG_RIGHT : DEG_DOWN;
    end else begin
      yaw_nxt   = yaw_m;
      pitch_nxt = pitch_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (e_out) begin
      out_valid_r <= step_valid[SEARCH_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (e_out && step_valid[SEARCH_STEPS]) begin
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2*DEG_W){1'b0}}, yaw_r, pitch_r};

endmodule
